// File: src/gprs_pkg.sv
// ----------------------------------------------------------------------------
// gprs_pkg: shared types and constants
// Widths, codes and state encoding for the population roulette selector.
// ----------------------------------------------------------------------------
package gprs_pkg;

  localparam int POP_SIZE = 256;
  localparam int AW       = $clog2(POP_SIZE);
  localparam int CW       = $clog2(POP_SIZE + 1);
  localparam int ID_W     = 16;
  localparam int SC_W     = 24;
  localparam int SCALE_W  = 16;
  localparam int FRAC_W   = 16;
  localparam int RIDX_W   = 8;
  localparam int SPREAD_W = SC_W + SCALE_W;
  localparam int FIT_W    = SPREAD_W + 1;
  localparam int SUM_W    = FIT_W + AW + 1;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd512;

  // register index: taken from paddr[2]
  localparam logic REG_FITNESS_SCALE = 1'b0;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_ERASE  = 2'd1,
    ACT_SELECT = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [SC_W-1:0] score;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_SH,
    S_INS_LAST,
    S_ST_W,
    S_ST_B,
    S_ST_C,
    S_SEL_DEC,
    S_SEL_CAP,
    S_MUL,
    S_PASS,
    S_PT1,
    S_PT2,
    S_OUT
  } fsm_t;

endpackage

// File: src/gprs_if.sv
// ----------------------------------------------------------------------------
// gprs_if: stream interfaces
// Valid/ready channels for the request and result transactions.
// ----------------------------------------------------------------------------
interface gprs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] entry_id;
  logic [23:0] score;
  logic [15:0] rand_fraction;
  logic [7:0]  rand_index;

  modport source (output valid, action, entry_id, score, rand_fraction, rand_index,
                  input ready);
  modport sink   (input valid, action, entry_id, score, rand_fraction, rand_index,
                  output ready);
endinterface

interface gprs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] selected_id;
  logic [23:0] selected_score;
  logic [23:0] best_score;
  logic [23:0] worst_score;
  logic [8:0]  entry_count;
  logic [1:0]  status;

  modport source (output valid, selected_id, selected_score, best_score, worst_score,
                  entry_count, status, input ready);
  modport sink   (input valid, selected_id, selected_score, best_score, worst_score,
                  entry_count, status, output ready);
endinterface

// File: src/gprs_table.sv
// ----------------------------------------------------------------------------
// gprs_table: population entry memory
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module gprs_table (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [gprs_pkg::AW-1:0] rd_addr,
  output gprs_pkg::entry_t      rd_data,
  input  logic                  wr_en,
  input  logic [gprs_pkg::AW-1:0] wr_addr,
  input  gprs_pkg::entry_t      wr_data
);
  import gprs_pkg::*;

  entry_t mem [POP_SIZE];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/ga_population_roulette_select.sv
// ----------------------------------------------------------------------------
// ga_population_roulette_select: sorted population with roulette selection
// Flow: refused or unused actions go straight to the result; an insert into an empty
//   table writes rank zero, else moves k entries up (k <= fill); erase and insert
//   then refresh worst and best. A select with equal scores reads one entry; any
//   other select walks the table memory twice, one entry a cycle through its single
//   read port, plus setup steps. Throughput: one transaction at a time; the next is
//   taken once the result is in the output register. Reset: synchronous active-low
//   rst_n empties the table and sets the scale to 2.0; the table memory itself is not cleared.
// ----------------------------------------------------------------------------
module ga_population_roulette_select (
  input  logic                       clk,
  input  logic                       rst_n,
  gprs_in_if.sink                    in_chan,
  gprs_out_if.source                 out_chan,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gprs_pkg::PADDR_W-1:0] paddr,
  input  logic [gprs_pkg::PDATA_W-1:0] pwdata,
  output logic [gprs_pkg::PDATA_W-1:0] prdata,
  output logic                       pready
);
  import gprs_pkg::*;

  fsm_t state_r, state_nxt;

  // table bookkeeping: entries live at physical base_r + rank
  logic [AW-1:0]      base_r;
  logic [CW-1:0]      fill_r;
  logic [SCALE_W-1:0] scale_r;

  // latched request
  logic [ID_W-1:0]    id_r;
  logic [SC_W-1:0]    sc_r;
  logic [FRAC_W-1:0]  frac_r;
  logic [RIDX_W-1:0]  ridx_r;

  logic [CW-1:0]      cnt_r;
  logic [SC_W-1:0]    worst_r, best_r;
  logic [SPREAD_W-1:0] spread_r;

  // walk pipeline: read -> fit -> accumulate
  logic               walk_r, v1_r, l1_r, v2_r, l2_r;
  logic [FIT_W-1:0]   fit_r;
  logic [ID_W-1:0]    fid_r;
  logic [SC_W-1:0]    fsc_r;
  logic [SUM_W-1:0]   acc_r, acc_nxt, point_r, mhi_r;
  logic [2*FRAC_W-1:0] mlo_r;

  logic [ID_W-1:0]    sel_id_r;
  logic [SC_W-1:0]    sel_sc_r;
  status_t            status_r;

  logic               out_valid_r;
  logic [ID_W-1:0]    out_id_r;
  logic [SC_W-1:0]    out_sel_r, out_best_r, out_worst_r;
  logic [CW-1:0]      out_cnt_r;
  status_t            out_status_r;

  // memory port controls
  logic               rd_en, wr_en;
  logic [CW-1:0]      rd_rank, wr_rank;
  entry_t             rd_data, wr_data;

  logic               in_fire, out_load, ins_done, walk_hit, table_full, table_empty;
  logic [SC_W-1:0]    fit_diff;
  logic [SPREAD_W-1:0] spread_prod;

  assign in_fire     = in_chan.valid && in_chan.ready;
  assign table_full  = (fill_r == CW'(POP_SIZE));
  assign table_empty = (fill_r == '0);
  assign acc_nxt     = acc_r + SUM_W'(fit_r);
  assign walk_hit    = (acc_nxt >= point_r) || l2_r;
  assign fit_diff    = rd_data.score - worst_r;
  assign spread_prod = (best_r - worst_r) * scale_r;
  assign out_load    = (state_r == S_OUT) && (!out_valid_r || out_chan.ready);

  gprs_table u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (base_r + rd_rank[AW-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (base_r + wr_rank[AW-1:0]),
    .wr_data (wr_data)
  );

  // next state and memory port controls
  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    rd_rank   = '0;
    wr_en     = 1'b0;
    wr_rank   = '0;
    wr_data   = '{id: id_r, score: sc_r};
    ins_done  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (action_t'(in_chan.action))
            ACT_INSERT: begin
              if (table_full) begin
                state_nxt = S_OUT;
              end else if (table_empty) begin
                // first entry goes straight to rank zero
                wr_en     = 1'b1;
                wr_data   = '{id: in_chan.entry_id, score: in_chan.score};
                state_nxt = S_ST_W;
              end else begin
                state_nxt = S_INS_RD;
              end
            end
            ACT_ERASE:  state_nxt = table_empty ? S_OUT : S_ST_W;
            ACT_SELECT: state_nxt = table_empty ? S_OUT : S_SEL_DEC;
            default:    state_nxt = S_OUT;
          endcase
        end
      end
      S_INS_RD: begin
        rd_en     = 1'b1;
        rd_rank   = fill_r - 1'b1;
        state_nxt = S_INS_SH;
      end
      S_INS_SH: begin
        // move larger entries up one rank from the top down
        wr_en   = 1'b1;
        wr_rank = cnt_r + 1'b1;
        if (rd_data.score > sc_r) begin
          wr_data = rd_data;
          if (cnt_r == '0) begin
            state_nxt = S_INS_LAST;
          end else begin
            rd_en   = 1'b1;
            rd_rank = cnt_r - 1'b1;
          end
        end else begin
          ins_done  = 1'b1;
          state_nxt = S_ST_W;
        end
      end
      S_INS_LAST: begin
        wr_en     = 1'b1;
        ins_done  = 1'b1;
        state_nxt = S_ST_W;
      end
      S_ST_W: begin
        if (table_empty) begin
          state_nxt = S_OUT;
        end else begin
          rd_en     = 1'b1;
          state_nxt = S_ST_B;
        end
      end
      S_ST_B: begin
        rd_en     = 1'b1;
        rd_rank   = fill_r - 1'b1;
        state_nxt = S_ST_C;
      end
      S_ST_C: state_nxt = S_OUT;
      S_SEL_DEC: begin
        if (best_r == worst_r) begin
          rd_en     = 1'b1;
          rd_rank   = (CW'(ridx_r) < fill_r) ? CW'(ridx_r) : fill_r - 1'b1;
          state_nxt = S_SEL_CAP;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_SEL_CAP: state_nxt = S_OUT;
      S_MUL:     state_nxt = S_PASS;
      S_PASS: begin
        if (cnt_r < fill_r) begin
          rd_en   = 1'b1;
          rd_rank = cnt_r;
        end
        if (v2_r) begin
          if (!walk_r && l2_r) begin
            state_nxt = S_PT1;
          end else if (walk_r && walk_hit) begin
            state_nxt = S_OUT;
          end
        end
      end
      S_PT1: state_nxt = S_PT2;
      S_PT2: state_nxt = S_PASS;
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      fill_r      <= '0;
      scale_r     <= SCALE_RESET;
      worst_r     <= '0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr[2] == REG_FITNESS_SCALE) begin
        scale_r <= pwdata[SCALE_W-1:0];
      end
      if (in_fire && action_t'(in_chan.action) == ACT_INSERT && !table_full
          && table_empty) begin
        fill_r <= fill_r + 1'b1;
      end
      if (in_fire && action_t'(in_chan.action) == ACT_ERASE && !table_empty) begin
        // drop the worst entry by advancing the base
        base_r <= base_r + 1'b1;
        fill_r <= fill_r - 1'b1;
      end
      if (ins_done) begin
        fill_r <= fill_r + 1'b1;
      end
      if (state_r == S_ST_W && table_empty) begin
        worst_r <= '0;
        best_r  <= '0;
      end
      if (state_r == S_ST_B) begin
        worst_r <= rd_data.score;
      end
      if (state_r == S_ST_C) begin
        best_r <= rd_data.score;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_PASS) begin
        v1_r <= (cnt_r < fill_r);
        v2_r <= v1_r;
      end else begin
        v1_r <= 1'b0;
        v2_r <= 1'b0;
      end
    end
  end

  // payload and datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      id_r     <= in_chan.entry_id;
      sc_r     <= in_chan.score;
      frac_r   <= in_chan.rand_fraction;
      ridx_r   <= in_chan.rand_index;
      sel_id_r <= '0;
      sel_sc_r <= '0;
      status_r <= STAT_OK;
      if (action_t'(in_chan.action) == ACT_INSERT && table_full) begin
        status_r <= STAT_FULL;
      end
      if ((action_t'(in_chan.action) == ACT_ERASE
           || action_t'(in_chan.action) == ACT_SELECT) && table_empty) begin
        status_r <= STAT_EMPTY;
      end
    end
    case (state_r)
      S_INS_RD: cnt_r <= fill_r - 1'b1;
      S_INS_SH: cnt_r <= cnt_r - 1'b1;
      S_SEL_CAP: begin
        sel_id_r <= rd_data.id;
        sel_sc_r <= rd_data.score;
      end
      S_MUL: begin
        spread_r <= spread_prod;
        cnt_r    <= '0;
        acc_r    <= '0;
        walk_r   <= 1'b0;
      end
      S_PASS: begin
        if (cnt_r < fill_r) begin
          cnt_r <= cnt_r + 1'b1;
          l1_r  <= (cnt_r == fill_r - 1'b1);
        end
        if (v1_r) begin
          fit_r <= FIT_W'({fit_diff, 8'b0}) + FIT_W'(spread_r);
          fid_r <= rd_data.id;
          fsc_r <= rd_data.score;
          l2_r  <= l1_r;
        end
        if (v2_r) begin
          acc_r <= acc_nxt;
          if (walk_r && walk_hit) begin
            sel_id_r <= fid_r;
            sel_sc_r <= fsc_r;
          end
        end
      end
      S_PT1: begin
        // point = frac * total / 65536, split into high and low halves
        mhi_r <= SUM_W'(frac_r * acc_r[SUM_W-1:FRAC_W]);
        mlo_r <= frac_r * acc_r[FRAC_W-1:0];
      end
      S_PT2: begin
        point_r <= mhi_r + SUM_W'(mlo_r[2*FRAC_W-1:FRAC_W]);
        cnt_r   <= '0;
        acc_r   <= '0;
        walk_r  <= 1'b1;
      end
      default: ;
    endcase
    if (out_load) begin
      out_id_r     <= sel_id_r;
      out_sel_r    <= sel_sc_r;
      out_best_r   <= best_r;
      out_worst_r  <= worst_r;
      out_cnt_r    <= fill_r;
      out_status_r <= status_r;
    end
  end

  assign in_chan.ready           = (state_r == S_IDLE);
  assign out_chan.valid          = out_valid_r;
  assign out_chan.selected_id    = out_id_r;
  assign out_chan.selected_score = out_sel_r;
  assign out_chan.best_score     = out_best_r;
  assign out_chan.worst_score    = out_worst_r;
  assign out_chan.entry_count    = out_cnt_r;
  assign out_chan.status         = out_status_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FITNESS_SCALE) ? PDATA_W'(scale_r) : '0;

endmodule

// File: src/gprs_checker.sv
// ----------------------------------------------------------------------------
// gprs_checker: port-level checks
// Result channel consistency over time, attached to the top level by bind.
// ----------------------------------------------------------------------------
module gprs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] selected_id,
  input logic [23:0] best_score,
  input logic [23:0] worst_score,
  input logic [8:0]  entry_count,
  input logic [1:0]  status
);
  import gprs_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(selected_id))
    else $error("result dropped or changed while stalled");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> entry_count <= 9'(POP_SIZE))
    else $error("entry count beyond table size");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == STAT_FULL |-> entry_count == 9'(POP_SIZE))
    else $error("full status with room left");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == STAT_EMPTY |-> entry_count == '0 && selected_id == '0)
    else $error("empty status with entries held");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> best_score >= worst_score)
    else $error("best score below worst score");

endmodule

bind ga_population_roulette_select gprs_checker u_gprs_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .selected_id (out_chan.selected_id),
  .best_score  (out_chan.best_score),
  .worst_score (out_chan.worst_score),
  .entry_count (out_chan.entry_count),
  .status      (out_chan.status)
);

// File: verif/ga_population_roulette_select_test.sv
// ----------------------------------------------------------------------------
// ga_population_roulette_select_test: self-checking bench for the selector
// Drives insert, erase, select and unused-action transactions with random gaps and result
// back-pressure, predicts every result from a behavioral population table,
// and compares each result field by field in order.
// ----------------------------------------------------------------------------
module ga_population_roulette_select_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gprs_pkg::*;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] entry_id;
    logic [23:0] score;
    logic [15:0] rand_fraction;
    logic [7:0]  rand_index;
  } request_t;

  typedef struct packed {
    logic [15:0] selected_id;
    logic [23:0] selected_score;
    logic [23:0] best_score;
    logic [23:0] worst_score;
    logic [8:0]  entry_count;
    logic [1:0]  status;
  } outcome_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  gprs_in_if  in_chan ();
  gprs_out_if out_chan ();

  ga_population_roulette_select u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Behavioral population: sorted ascending, older first among equal scores.
  logic [23:0] pop_score [POP_SIZE];
  logic [15:0] pop_id    [POP_SIZE];
  int          pop_fill;
  logic [15:0] scale_q88;

  request_t pending_req[$];
  outcome_t expected_out[$];
  int       err_count = 0;
  longint   cycle_count = 0;
  bit       hold_sender;
  int       send_gap;
  int       recv_gap;

  // Work out one transaction's result and advance the population.
  function automatic outcome_t apply_request(request_t rq);
    outcome_t    res;
    int          pos, pick;
    logic [23:0] worst, best;
    logic [63:0] spread, total, point, run, fit;
    res = '0;
    case (action_t'(rq.action))
      ACT_INSERT: begin
        if (pop_fill >= POP_SIZE) begin
          res.status = STAT_FULL;
        end else begin
          pos = pop_fill;
          for (int i = 0; i < pop_fill; i++)
            if (pop_score[i] > rq.score) begin
              pos = i;
              break;
            end
          for (int i = pop_fill; i > pos; i--) begin
            pop_score[i] = pop_score[i-1];
            pop_id[i]    = pop_id[i-1];
          end
          pop_score[pos] = rq.score;
          pop_id[pos]    = rq.entry_id;
          pop_fill++;
        end
      end
      ACT_ERASE: begin
        if (pop_fill == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          for (int i = 1; i < pop_fill; i++) begin
            pop_score[i-1] = pop_score[i];
            pop_id[i-1]    = pop_id[i];
          end
          pop_fill--;
        end
      end
      ACT_SELECT: begin
        if (pop_fill == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          worst = pop_score[0];
          best  = pop_score[pop_fill-1];
          pick  = pop_fill - 1;
          if (best == worst) begin
            pick = (rq.rand_index < pop_fill) ? int'(rq.rand_index) : pop_fill - 1;
          end else begin
            spread = 64'(best - worst) * 64'(scale_q88);
            total  = 0;
            for (int i = 0; i < pop_fill; i++)
              total += (64'(pop_score[i] - worst) << 8) + spread;
            point = 64'(rq.rand_fraction) * (total >> 16)
                  + ((64'(rq.rand_fraction) * (total & 64'hFFFF)) >> 16);
            run = 0;
            for (int i = 0; i < pop_fill; i++) begin
              fit = (64'(pop_score[i] - worst) << 8) + spread;
              run += fit;
              if (run >= point) begin
                pick = i;
                break;
              end
            end
          end
          res.selected_id    = pop_id[pick];
          res.selected_score = pop_score[pick];
        end
      end
      default: ;
    endcase
    res.best_score  = pop_fill ? pop_score[pop_fill-1] : '0;
    res.worst_score = pop_fill ? pop_score[0] : '0;
    res.entry_count = 9'(pop_fill);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycle_count);
    err_count++;
  endtask

  // Queue one transaction, predicting its result now (order is preserved).
  task automatic queue_request(logic [1:0] act, logic [15:0] id, logic [23:0] sc,
                               logic [15:0] frac, logic [7:0] ridx);
    request_t rq;
    rq = '{act, id, sc, frac, ridx};
    pending_req  = {pending_req, rq};
    expected_out = {expected_out, apply_request(rq)};
  endtask

  // No gap half the time, mostly short gaps otherwise, and a long one now and then.
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Sender: present the head of the queue, drop it once accepted.
  always @(posedge clk) begin
    int gap;
    if (!rst_n) begin
      in_chan.valid         <= 1'b0;
      in_chan.action        <= '0;
      in_chan.entry_id      <= '0;
      in_chan.score         <= '0;
      in_chan.rand_fraction <= '0;
      in_chan.rand_index    <= '0;
      send_gap              <= 0;
    end else if (in_chan.valid && in_chan.ready) begin
      void'(pending_req.pop_front());
      gap = draw_gap();
      if (gap == 0 && pending_req.size() > 0 && !hold_sender) begin
        {in_chan.action, in_chan.entry_id, in_chan.score, in_chan.rand_fraction,
         in_chan.rand_index} <= pending_req[0];
        send_gap <= 0;
      end else begin
        in_chan.valid <= 1'b0;
        send_gap      <= gap;
      end
    end else if (!in_chan.valid) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (pending_req.size() > 0 && !hold_sender) begin
        in_chan.valid <= 1'b1;
        {in_chan.action, in_chan.entry_id, in_chan.score, in_chan.rand_fraction,
         in_chan.rand_index} <= pending_req[0];
      end
    end
  end

  // Receiver: random back-pressure, compare each accepted result.
  always @(posedge clk) begin
    outcome_t got, want;
    int       gap;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      recv_gap       <= 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got = '{out_chan.selected_id, out_chan.selected_score, out_chan.best_score,
                out_chan.worst_score, out_chan.entry_count, out_chan.status};
        if (expected_out.size() == 0) begin
          report_mismatch("unexpected result", longint'(got.entry_count), 0);
        end else begin
          want = expected_out.pop_front();
          if (got.selected_id !== want.selected_id)
            report_mismatch("selected_id", longint'(got.selected_id),
                            longint'(want.selected_id));
          if (got.selected_score !== want.selected_score)
            report_mismatch("selected_score", longint'(got.selected_score),
                            longint'(want.selected_score));
          if (got.best_score !== want.best_score)
            report_mismatch("best_score", longint'(got.best_score),
                            longint'(want.best_score));
          if (got.worst_score !== want.worst_score)
            report_mismatch("worst_score", longint'(got.worst_score),
                            longint'(want.worst_score));
          if (got.entry_count !== want.entry_count)
            report_mismatch("entry_count", longint'(got.entry_count),
                            longint'(want.entry_count));
          if (got.status !== want.status)
            report_mismatch("status", longint'(got.status), longint'(want.status));
        end
      end
      if (recv_gap > 0) begin
        recv_gap       <= recv_gap - 1;
        out_chan.ready <= 1'b0;
      end else if (out_chan.valid && out_chan.ready) begin
        gap = draw_gap();
        recv_gap       <= gap;
        out_chan.ready <= (gap == 0);
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Hard stop well past the slowest correct run.
  always @(posedge clk) begin
    if (cycle_count > 64'd3_000_000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_req.size() > 0 || expected_out.size() > 0) @(posedge clk);
    // Hold off so any trailing work settles before touching the register.
    repeat (600) @(posedge clk);
  endtask

  task automatic write_scale(logic [15:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= '0;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    scale_q88 = value;
  endtask

  // One phase of random traffic: inserts at weight ins_weight, then erases, selects and rare unused actions.
  task automatic random_phase(int count, int ins_weight);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < ins_weight)
        queue_request(ACT_INSERT, 16'($urandom),
                      ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 40)),
                      16'($urandom), 8'($urandom));
      else if (r < ins_weight + 20)
        queue_request(ACT_ERASE, 16'($urandom), 24'($urandom), 16'($urandom), 8'($urandom));
      else if (r < 98)
        queue_request(ACT_SELECT, 16'($urandom), 24'($urandom), 16'($urandom),
                      ($urandom_range(0, 1)) ? 8'($urandom_range(0, 8)) : 8'($urandom));
      else
        queue_request(ACT_NONE, 16'($urandom), 24'($urandom), 16'($urandom), 8'($urandom));
      if (n % 64 == 63) @(posedge clk);
    end
  endtask

  initial begin
    logic [15:0] scales [5];
    scales = '{16'd0, 16'd1, 16'hFFFF, 16'd256, 16'd512};
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    hold_sender = 0;
    pop_fill = 0;
    scale_q88 = SCALE_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-table refusals, unused action, extremes, equal scores.
    queue_request(ACT_ERASE,  16'h0, 24'h0, 16'h0, 8'h0);
    queue_request(ACT_SELECT, 16'hFFFF, 24'hFFFFFF, 16'hFFFF, 8'hFF);
    queue_request(ACT_NONE,   16'hFFFF, 24'hFFFFFF, 16'hFFFF, 8'hFF);
    queue_request(ACT_INSERT, 16'hFFFF, 24'd7, 16'h0, 8'h0);
    queue_request(ACT_INSERT, 16'h0001, 24'd7, 16'h0, 8'h0);
    queue_request(ACT_SELECT, 16'h0, 24'h0, 16'h1234, 8'd1);
    queue_request(ACT_SELECT, 16'h0, 24'h0, 16'h1234, 8'hFF);
    queue_request(ACT_INSERT, 16'h0002, 24'hFFFFFF, 16'h0, 8'h0);
    queue_request(ACT_INSERT, 16'h0003, 24'h0, 16'h0, 8'h0);
    queue_request(ACT_SELECT, 16'h0, 24'h0, 16'h0000, 8'h0);
    queue_request(ACT_SELECT, 16'h0, 24'h0, 16'hFFFF, 8'h0);
    queue_request(ACT_SELECT, 16'h0, 24'h0, 16'h8000, 8'h0);
    queue_request(ACT_NONE,   16'h0, 24'h0, 16'h0, 8'h0);
    queue_request(ACT_ERASE,  16'h0, 24'h0, 16'h0, 8'h0);
    queue_request(ACT_SELECT, 16'hAAAA, 24'h555555, 16'h5555, 8'hAA);
    // Wait until all results are back before queueing more.
    wait_drained();

    // Fill to the top and push past it.
    for (int i = 0; i < POP_SIZE + 3; i++)
      queue_request(ACT_INSERT, 16'($urandom), 24'($urandom_range(0, 1000)), 16'h0, 8'h0);
    queue_request(ACT_SELECT, 16'h0, 24'h0, 16'($urandom), 8'($urandom));
    wait_drained();
    write_scale(16'hFFFF);
    queue_request(ACT_SELECT, 16'h0, 24'h0, 16'hFFFF, 8'h0);
    queue_request(ACT_SELECT, 16'h0, 24'h0, 16'h0001, 8'h0);
    for (int i = 0; i < POP_SIZE + 2; i++)
      queue_request(ACT_ERASE, 16'h0, 24'h0, 16'h0, 8'h0);
    wait_drained();

    // Random phases across scale settings, including zero and the reset value.
    foreach (scales[k]) begin
      write_scale(scales[k]);
      random_phase(k == 0 ? 170 : 150, k % 2 ? 45 : 55);
      wait_drained();
    end

    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
src/gprs_pkg.sv
src/gprs_if.sv
src/gprs_table.sv
src/ga_population_roulette_select.sv
src/gprs_checker.sv
verif/ga_population_roulette_select_test.sv
